FILE: rtl/mdnsq_pkg.sv
// ----------------------------------------------------------------------------
// mdnsq_pkg
// Shared types, constants and helpers of the mDNS A query responder.
// ----------------------------------------------------------------------------
package mdnsq_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 512;
  localparam int unsigned MIN_PACKET_BYTES     = 12;
  localparam int unsigned MAX_HOST_CHARS       = 32;
  localparam int unsigned MAX_LABEL_LEN        = 63;
  localparam int unsigned HEADER_LAST_IDX      = 11;
  localparam int unsigned QR_FLAGS_IDX         = 2;
  localparam int unsigned QDCOUNT_HI_IDX       = 4;
  localparam int unsigned QDCOUNT_LO_IDX       = 5;
  localparam int unsigned LOCAL_SUFFIX_LEN     = 6;  // ".local"

  // answer layout
  localparam int unsigned ANS_NAME_OFFSET = 13;  // first hostname byte
  localparam int unsigned ANS_FIXED_BYTES = 34;  // everything but the hostname
  localparam int unsigned MAX_WORDS       = (MAX_HOST_CHARS + ANS_FIXED_BYTES + 7) / 8;
  localparam int unsigned WORD_W          = $clog2(MAX_WORDS);

  localparam logic [15:0] ANS_FLAGS = 16'h8400;
  localparam logic [15:0] ANS_CLASS = 16'h8001;
  localparam logic [31:0] ANS_TTL   = 32'd120;
  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_ANY  = 16'd255;
  localparam logic [7:0]  CHAR_DOT  = 8'h2e;

  typedef enum logic [2:0] {
    VERD_ANSWER     = 3'd0,
    VERD_BAD_LENGTH = 3'd1,
    VERD_NOT_QUERY  = 3'd2,
    VERD_MALFORMED  = 3'd3,
    VERD_NOT_ASKED  = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LABEL_LEN,
    PH_LABEL_CHARS,
    PH_TAIL,
    PH_DONE,
    PH_BAD
  } phase_e;

  typedef enum logic [2:0] {
    CFG_HOST_0   = 3'd0,
    CFG_HOST_1   = 3'd1,
    CFG_HOST_2   = 3'd2,
    CFG_HOST_3   = 3'd3,
    CFG_HOST_LEN = 3'd4,
    CFG_IP       = 3'd5
  } cfg_idx_e;

  typedef logic [3:0][63:0] host_t;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       last_byte;
  } query_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [63:0] response_word;
    logic [3:0]  valid_bytes;
    logic        final_word;
  } result_t;

  typedef struct packed {
    host_t       host;
    logic [5:0]  host_n;   // clamped hostname length, 1 to MAX_HOST_CHARS
    logic [31:0] ip;
  } cfg_t;

  // end-of-packet event from the parser to the answer unit
  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } pkt_ev_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [5:0] host_len(input logic [5:0] len);
    logic [5:0] n;
    n = len;
    if (n == 6'd0) n = 6'd1;
    if (n > 6'(MAX_HOST_CHARS)) n = 6'(MAX_HOST_CHARS);
    return n;
  endfunction

  function automatic logic [7:0] host_char(input host_t host, input logic [4:0] i);
    logic [63:0] w;
    w = host[i[4:3]];
    return to_lower(w[{~i[2:0], 3'b000} +: 8]);
  endfunction

  function automatic logic [7:0] local_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h6c;  // l
      3'd1:    c = 8'h6f;  // o
      3'd2:    c = 8'h63;  // c
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h6c;  // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/mdnsq_parser.sv
// ----------------------------------------------------------------------------
// mdnsq_parser
// Byte-wise mDNS header and question walker; one byte per cycle while accept is high,
// reports a verdict on the last byte of each packet.
// ----------------------------------------------------------------------------
module mdnsq_parser import mdnsq_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  query_t  in_i,
  input  cfg_t    cfg_i,
  output pkt_ev_t ev_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2);

  logic [CNT_W-1:0] cnt_q, cnt_n, cnt_d;
  logic [15:0]      qtotal_q, qtotal_n, qtotal_d;
  logic [15:0]      qdone_q, qdone_n, qdone_d;
  phase_e           phase_q, phase_n, phase_d;
  logic [5:0]       lrem_q, lrem_n, lrem_d;
  logic [5:0]       pos_q, pos_n, pos_d;
  logic             match_q, match_n, match_d;
  logic             started_q, started_n, started_d;
  logic [15:0]      type_q, type_n, type_d;
  logic [1:0]       tail_q, tail_n, tail_d;
  logic             want_q, want_n, want_d;
  logic             resp_q, resp_n, resp_d;

  logic       cmp_en;
  logic [7:0] cmp_c;
  logic [7:0] b;

  assign b = in_i.query_byte;

  // name compare against hostname + ".local"
  function automatic logic exp_match(input logic [5:0] pos, input logic [7:0] c,
                                     input cfg_t cfg);
    logic [6:0] p7;
    logic [6:0] n7;
    logic [6:0] k;
    logic       ok;
    p7 = {1'b0, pos};
    n7 = {1'b0, cfg.host_n};
    k  = p7 - n7 - 7'd1;
    if (p7 < n7) begin
      ok = (host_char(cfg.host, pos[4:0]) == c);
    end else if (p7 == n7) begin
      ok = (c == CHAR_DOT);
    end else if (p7 < n7 + 7'(LOCAL_SUFFIX_LEN)) begin
      ok = (local_char(k[2:0]) == c);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // next state
  always_comb begin
    cnt_n     = cnt_q;
    qtotal_n  = qtotal_q;
    qdone_n   = qdone_q;
    phase_n   = phase_q;
    lrem_n    = lrem_q;
    pos_n     = pos_q;
    match_n   = match_q;
    started_n = started_q;
    type_n    = type_q;
    tail_n    = tail_q;
    want_n    = want_q;
    resp_n    = resp_q;
    cmp_en    = 1'b0;
    cmp_c     = to_lower(b);

    case (phase_q)
      PH_HEADER: begin
        if (cnt_q == CNT_W'(QR_FLAGS_IDX)) begin
          resp_n = b[7];
        end else if (cnt_q == CNT_W'(QDCOUNT_HI_IDX)) begin
          qtotal_n = {b, 8'h00};
        end else if (cnt_q == CNT_W'(QDCOUNT_LO_IDX)) begin
          qtotal_n = qtotal_q | {8'h00, b};
        end
        if (cnt_q >= CNT_W'(HEADER_LAST_IDX)) begin
          if (qtotal_n == 16'd0) begin
            phase_n = PH_DONE;
          end else begin
            phase_n   = PH_LABEL_LEN;
            lrem_n    = '0;
            pos_n     = '0;
            match_n   = 1'b1;
            started_n = 1'b0;
            type_n    = '0;
            tail_n    = '0;
          end
        end
      end
      PH_LABEL_LEN: begin
        if (b == 8'd0) begin
          phase_n = PH_TAIL;
          tail_n  = '0;
        end else if (b > 8'(MAX_LABEL_LEN)) begin
          phase_n = PH_BAD;
        end else begin
          // labels are joined with a dot before the compare
          cmp_en    = started_q;
          cmp_c     = CHAR_DOT;
          started_n = 1'b1;
          lrem_n    = b[5:0];
          phase_n   = PH_LABEL_CHARS;
        end
      end
      PH_LABEL_CHARS: begin
        cmp_en = 1'b1;
        lrem_n = lrem_q - 6'd1;
        if (lrem_n == 6'd0) phase_n = PH_LABEL_LEN;
      end
      PH_TAIL: begin
        if (tail_q == 2'd0) begin
          type_n = {b, 8'h00};
        end else if (tail_q == 2'd1) begin
          type_n = type_q | {8'h00, b};
        end
        if (tail_q == 2'd3) begin
          if (match_q && (pos_q == cfg_i.host_n + 6'(LOCAL_SUFFIX_LEN)) &&
              (type_q == TYPE_A || type_q == TYPE_ANY)) begin
            want_n = 1'b1;
          end
          qdone_n = qdone_q + 16'd1;
          if (qdone_n >= qtotal_q) begin
            phase_n = PH_DONE;
          end else begin
            phase_n   = PH_LABEL_LEN;
            lrem_n    = '0;
            pos_n     = '0;
            match_n   = 1'b1;
            started_n = 1'b0;
            type_n    = '0;
            tail_n    = '0;
          end
        end else begin
          tail_n = tail_q + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (cmp_en) begin
      if (!exp_match(pos_q, cmp_c, cfg_i)) match_n = 1'b0;
      if (pos_q < 6'(MAX_LABEL_LEN)) pos_n = pos_q + 6'd1;
    end

    if (cnt_q <= CNT_W'(MAX_PACKET_BYTES)) cnt_n = cnt_q + CNT_W'(1);

    cnt_d     = cnt_n;
    qtotal_d  = qtotal_n;
    qdone_d   = qdone_n;
    phase_d   = phase_n;
    lrem_d    = lrem_n;
    pos_d     = pos_n;
    match_d   = match_n;
    started_d = started_n;
    type_d    = type_n;
    tail_d    = tail_n;
    want_d    = want_n;
    resp_d    = resp_n;

    // packet end: back to the header
    if (in_i.last_byte) begin
      cnt_d     = '0;
      qtotal_d  = '0;
      qdone_d   = '0;
      phase_d   = PH_HEADER;
      lrem_d    = '0;
      pos_d     = '0;
      match_d   = 1'b1;
      started_d = 1'b0;
      type_d    = '0;
      tail_d    = '0;
      want_d    = 1'b0;
      resp_d    = 1'b0;
    end
  end

  // verdict on the last byte
  always_comb begin
    ev_o.valid = accept_i & in_i.last_byte;
    if (cnt_n < CNT_W'(MIN_PACKET_BYTES) || cnt_n > CNT_W'(MAX_PACKET_BYTES)) begin
      ev_o.verdict = VERD_BAD_LENGTH;
    end else if (resp_n) begin
      ev_o.verdict = VERD_NOT_QUERY;
    end else if (phase_n == PH_BAD || phase_n == PH_LABEL_CHARS || phase_n == PH_TAIL ||
                 (phase_n == PH_LABEL_LEN && started_n)) begin
      ev_o.verdict = VERD_MALFORMED;
    end else if (!want_n) begin
      ev_o.verdict = VERD_NOT_ASKED;
    end else begin
      ev_o.verdict = VERD_ANSWER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      qtotal_q  <= '0;
      qdone_q   <= '0;
      phase_q   <= PH_HEADER;
      lrem_q    <= '0;
      pos_q     <= '0;
      match_q   <= 1'b1;
      started_q <= 1'b0;
      type_q    <= '0;
      tail_q    <= '0;
      want_q    <= 1'b0;
      resp_q    <= 1'b0;
    end else if (accept_i) begin
      cnt_q     <= cnt_d;
      qtotal_q  <= qtotal_d;
      qdone_q   <= qdone_d;
      phase_q   <= phase_d;
      lrem_q    <= lrem_d;
      pos_q     <= pos_d;
      match_q   <= match_d;
      started_q <= started_d;
      type_q    <= type_d;
      tail_q    <= tail_d;
      want_q    <= want_d;
      resp_q    <= resp_d;
    end
  end

  phase_q_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> !started_q && pos_q == 6'd0 && !want_q)
    else $error("header phase with question state left over");

  name_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (phase_q == PH_LABEL_LEN || phase_q == PH_LABEL_CHARS) |=>
    pos_q <= 6'(MAX_LABEL_LEN))
    else $error("name position out of range");

  ev_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.valid |=> phase_q == PH_HEADER && cnt_q == '0)
    else $error("parser not cleared after packet end");

endmodule

FILE: rtl/mdnsq_answer.sv
// ----------------------------------------------------------------------------
// mdnsq_answer
// Turns a packet verdict into result items: one status item, or the A
// answer unloaded as 64-bit words through the output register.
// ----------------------------------------------------------------------------
module mdnsq_answer import mdnsq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pkt_ev_t ev_i,
  input  cfg_t    cfg_i,
  output logic    busy_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic              job_valid_q, job_valid_d;
  verdict_e          job_verdict_q, job_verdict_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           item;
  logic              load;
  logic [6:0]        n_bytes;
  logic [6:0]        base;
  logic [6:0]        rem;

  // byte p of the answer message, zero past its end
  function automatic logic [7:0] ans_byte(input logic [6:0] p, input cfg_t cfg);
    logic [6:0] n7;
    logic [6:0] q;
    logic [6:0] h;
    logic [7:0] v;
    n7 = {1'b0, cfg.host_n};
    h  = p - 7'(ANS_NAME_OFFSET);
    q  = p - 7'(ANS_NAME_OFFSET) - n7;
    v  = 8'h00;
    if (p < 7'(ANS_NAME_OFFSET - 1)) begin
      case (p)
        7'd2:    v = ANS_FLAGS[15:8];
        7'd3:    v = ANS_FLAGS[7:0];
        7'd7:    v = 8'd1;  // one answer
        default: v = 8'h00;
      endcase
    end else if (p == 7'(ANS_NAME_OFFSET - 1)) begin
      v = {2'b00, cfg.host_n};
    end else if (p < 7'(ANS_NAME_OFFSET) + n7) begin
      v = host_char(cfg.host, h[4:0]);
    end else begin
      case (q)
        7'd0:    v = 8'd5;
        7'd1:    v = local_char(3'd0);
        7'd2:    v = local_char(3'd1);
        7'd3:    v = local_char(3'd2);
        7'd4:    v = local_char(3'd3);
        7'd5:    v = local_char(3'd4);
        7'd7:    v = TYPE_A[15:8];
        7'd8:    v = TYPE_A[7:0];
        7'd9:    v = ANS_CLASS[15:8];
        7'd10:   v = ANS_CLASS[7:0];
        7'd11:   v = ANS_TTL[31:24];
        7'd12:   v = ANS_TTL[23:16];
        7'd13:   v = ANS_TTL[15:8];
        7'd14:   v = ANS_TTL[7:0];
        7'd16:   v = 8'd4;  // rdata length
        7'd17:   v = cfg.ip[31:24];
        7'd18:   v = cfg.ip[23:16];
        7'd19:   v = cfg.ip[15:8];
        7'd20:   v = cfg.ip[7:0];
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

  assign load    = !out_valid_q || !out_stall_i;
  assign n_bytes = 7'(cfg_i.host_n) + 7'(ANS_FIXED_BYTES);
  assign base    = {word_q, 3'b000};
  assign rem     = n_bytes - base;

  always_comb begin
    item.verdict       = job_verdict_q;
    item.response_word = '0;
    item.valid_bytes   = '0;
    item.final_word    = 1'b1;
    if (job_verdict_q == VERD_ANSWER) begin
      for (int i = 0; i < 8; i++) begin
        item.response_word[8*(7-i) +: 8] = ans_byte(base + 7'(i), cfg_i);
      end
      item.valid_bytes = (rem >= 7'd8) ? 4'd8 : rem[3:0];
      item.final_word  = (rem <= 7'd8);
    end
  end

  always_comb begin
    job_valid_d   = job_valid_q;
    job_verdict_d = job_verdict_q;
    word_d        = word_q;
    out_valid_d   = out_valid_q;
    if (load) begin
      out_valid_d = job_valid_q;
      if (job_valid_q) begin
        if (item.final_word) job_valid_d = 1'b0;
        else word_d = word_q + WORD_W'(1);
      end
    end
    if (ev_i.valid) begin
      job_valid_d   = 1'b1;
      job_verdict_d = ev_i.verdict;
      word_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q   <= 1'b0;
      job_verdict_q <= VERD_ANSWER;
      word_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      job_valid_q   <= job_valid_d;
      job_verdict_q <= job_verdict_d;
      word_q        <= word_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && job_valid_q) out_q <= item;
  end

  assign busy_o      = job_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  no_event_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_i.valid |-> !job_valid_q)
    else $error("packet verdict arrived while an answer is still unloading");

  status_item_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.verdict != VERD_ANSWER |->
    out_q.response_word == '0 && out_q.valid_bytes == '0 && out_q.final_word)
    else $error("status item carries answer data");

  full_mid_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.verdict == VERD_ANSWER && !out_q.final_word |->
    out_q.valid_bytes == 4'd8)
    else $error("short answer word before the final one");

  word_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> word_q < WORD_W'(MAX_WORDS))
    else $error("answer word index past the message end");

endmodule

FILE: rtl/mdns_a_query_responder.sv
// ----------------------------------------------------------------------------
// mdns_a_query_responder
// mDNS A query responder: parses one UDP payload byte per cycle and answers
// questions for <hostname>.local with a fixed authoritative A record.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per cycle; the last byte of a packet is held
//   off while the previous packet's answer is still unloading.
// Output: a packet's verdict is first registered as a pending job, then the first
//   result item is loaded into the output register; an answer takes 5 to 9 words at
//   one per cycle while the output is not stalled, set by the hostname length through the answer word counter.
// Reset: parser back to the header, no pending results, registers at defaults.
module mdns_a_query_responder import mdnsq_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  query_t      in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  host_t       host_q;
  logic [5:0]  hlen_q;
  logic [31:0] ip_q;
  cfg_t        cfg;
  pkt_ev_t     ev;
  logic        busy;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q <= '0;
      hlen_q <= 6'd1;
      ip_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOST_0:   host_q[0] <= cfg_data_i;
        CFG_HOST_1:   host_q[1] <= cfg_data_i;
        CFG_HOST_2:   host_q[2] <= cfg_data_i;
        CFG_HOST_3:   host_q[3] <= cfg_data_i;
        CFG_HOST_LEN: hlen_q    <= cfg_data_i[5:0];
        CFG_IP:       ip_q      <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.host   = host_q;
  assign cfg.host_n = host_len(hlen_q);
  assign cfg.ip     = ip_q;

  // only a packet end has to wait for the answer unit
  assign in_stall_o = busy & in_i.last_byte;
  assign accept     = in_valid_i & ~in_stall_o;

  mdnsq_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .ev_o    (ev)
  );

  mdnsq_answer u_answer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_i       (ev),
    .cfg_i      (cfg),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

endmodule
